[design/polynomial_multiply_assert.svh]
// Assertion shorthands used by the RTL of the polynomial multiplier.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef POLYNOMIAL_MULTIPLY_ASSERT_SVH
`define POLYNOMIAL_MULTIPLY_ASSERT_SVH

// same-cycle implication
`define PM_ASSERT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define PM_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/pm_pkg.sv]
package pm_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int COEF_BITS_DEF = 16;
  localparam int COEF_W        = 16;
  localparam int COEF_MAX_W    = 24;
  localparam int SUM_W         = 40;
  localparam int DEG_W         = 6;

  localparam logic OP_FIRST  = 1'b0;
  localparam logic OP_SECOND = 1'b1;

  typedef struct packed {
    logic             clear;
    logic             step;
    logic             shift;
    logic             start;
  } pm_cell_ctrl_t;

  typedef struct packed {
    logic [SUM_W-1:0] value;
    logic [DEG_W-1:0] degree;
    logic             last;
    logic             overflow;
  } pm_res_t;

  // exact product, kept modulo 2^SUM_W
  function automatic logic [SUM_W-1:0] pm_mul(input logic signed [COEF_MAX_W-1:0] a,
                                              input logic signed [COEF_MAX_W-1:0] b);
    logic signed [2*COEF_MAX_W-1:0] p;
    p = a * b;
    return p[SUM_W-1:0];
  endfunction

endpackage

[design/pm_in_if.sv]
interface pm_in_if;
  import pm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [COEF_W-1:0] coefficient;
  logic                     last;

  modport source (output valid, operation, coefficient, last, input ready);
  modport sink (input valid, operation, coefficient, last, output ready);
endinterface

[design/pm_out_if.sv]
interface pm_out_if;
  import pm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] product_coefficient;
  logic [DEG_W-1:0]        term_degree;
  logic                    last_term;
  logic                    overflow;

  modport source (output valid, product_coefficient, term_degree, last_term, overflow,
                  input ready);
  modport sink (input valid, product_coefficient, term_degree, last_term, overflow,
                output ready);
endinterface

[design/pm_cell.sv]
module pm_cell #(
  parameter int COEF_BITS = pm_pkg::COEF_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pm_pkg::pm_cell_ctrl_t                ctrl_i,
  input  logic                                 sel_i,
  input  logic signed [pm_pkg::COEF_MAX_W-1:0] coef_i,
  input  logic signed [pm_pkg::COEF_MAX_W-1:0] f_i,
  input  logic [pm_pkg::SUM_W-1:0]             acc_i,
  output logic signed [pm_pkg::COEF_MAX_W-1:0] f_o,
  output logic [pm_pkg::SUM_W-1:0]             acc_o
);
  import pm_pkg::*;

  logic signed [COEF_BITS-1:0] f_q;
  logic                        used_q, used_d;
  logic [SUM_W-1:0]            acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    if (sel_i) begin
      f_q <= coef_i[COEF_BITS-1:0];
    end
  end

  always_comb begin
    if (ctrl_i.start) begin
      used_d = sel_i;
    end else begin
      used_d = used_q | sel_i;
    end
  end

  // partial sum of this degree takes the sum from the right plus the
  // right neighbor's term times the broadcast coefficient on a step
  always_comb begin
    priority if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.step) begin
      acc_d = acc_i + pm_mul(f_i, coef_i);
    end else if (ctrl_i.shift) begin
      acc_d = acc_i;
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      used_q <= used_d;
      acc_q  <= acc_d;
    end
  end

  // unused terms read as zero
  assign f_o   = used_q ? COEF_MAX_W'(f_q) : '0;
  assign acc_o = acc_q;

endmodule

[design/pm_out_buf.sv]
module pm_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pm_pkg::pm_res_t push_data_i,
  output logic            space_o,
  output logic            valid_o,
  output pm_pkg::pm_res_t data_o,
  input  logic            ready_i
);
  import pm_pkg::*;

  logic    v0_q, v0_d, v1_q, v1_d;
  pm_res_t e0_q, e0_d, e1_q, e1_d;
  logic    pop;

  assign pop = v0_q && ready_i;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    e0_d = e0_q;
    e1_d = e1_q;
    unique case ({push_i, pop})
      2'b10: begin
        if (!v0_q) begin
          e0_d = push_data_i;
          v0_d = 1'b1;
        end else begin
          e1_d = push_data_i;
          v1_d = 1'b1;
        end
      end
      2'b01: begin
        e0_d = e1_q;
        v0_d = v1_q;
        v1_d = 1'b0;
      end
      2'b11: begin
        if (v1_q) begin
          e0_d = e1_q;
          e1_d = push_data_i;
        end else begin
          e0_d = push_data_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  // room is judged on the skid word alone, so the sink's ready has no combinational path to the source
  assign space_o = !v1_q;
  assign valid_o = v0_q;
  assign data_o  = e0_q;

endmodule

[design/polynomial_multiply.sv]
// Polynomial multiplier built as a transposed convolution: a row of MAX_TERMS
// cells holds the first polynomial and one running partial sum per pending
// product degree. Send the first polynomial lowest degree first (operation 0),
// marking its top coefficient last, then stream the second one (operation 1).
// Each second-polynomial word that follows a complete first one returns the
// product term of its own degree, since all cells update their sums in the
// same cycle. The last second word starts a flush that shifts the remaining
// n-1 partial sums out of the row, one per clock while the output buffer has
// room, where n is the number of first terms stored; input stalls until the
// flush ends. Results pass a two-word output buffer, so input never waits on
// the sink directly. Coefficients beyond MAX_TERMS are dropped and raise a
// sticky overflow flag that clears only on reset.
module polynomial_multiply #(
  parameter int MAX_TERMS = pm_pkg::MAX_TERMS_DEF,
  parameter int COEF_BITS = pm_pkg::COEF_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pm_in_if.sink       in_i,
  pm_out_if.source    out_o
);
  import pm_pkg::*;
  `include "polynomial_multiply_assert.svh"

  localparam int LEN_W = $clog2(MAX_TERMS + 1);

  logic [LEN_W-1:0] len_q, len_d, idx_q, idx_d, flush_left_q, flush_left_d;
  logic [DEG_W-1:0] flush_deg_q, flush_deg_d;
  logic             second_q, second_d, ovf_q, ovf_d, flush_q, flush_d;

  logic             space, in_ready, take, is_first, is_second, start, len_full;
  logic             step, fin, flush_go, push;
  logic [LEN_W-1:0] len_eff, idx_next;
  logic [SUM_W-1:0] head;
  pm_res_t          push_data, buf_data;
  pm_cell_ctrl_t    ctrl;

  logic signed [COEF_BITS-1:0]  coef_n;
  logic signed [COEF_MAX_W-1:0] coef_x;
  logic signed [COEF_MAX_W-1:0] f_link [MAX_TERMS+1];
  logic [SUM_W-1:0]             acc_link [MAX_TERMS+1];
  logic [MAX_TERMS-1:0]         sel;

  assign in_ready   = !flush_q && space;
  assign in_i.ready = in_ready;
  assign take       = in_i.valid && in_ready;

  assign is_first  = take && (in_i.operation == OP_FIRST);
  assign is_second = take && (in_i.operation == OP_SECOND) && second_q;
  assign start     = is_first && (second_q || (len_q == '0));
  assign len_eff   = start ? '0 : len_q;
  assign len_full  = (len_eff == LEN_W'(MAX_TERMS));
  assign step      = is_second && (idx_q < LEN_W'(MAX_TERMS));
  assign idx_next  = step ? LEN_W'(idx_q + 1'b1) : idx_q;
  assign fin       = is_second && in_i.last;
  assign flush_go  = fin && (len_q > LEN_W'(1));

  assign coef_n = COEF_BITS'(in_i.coefficient);
  assign coef_x = COEF_MAX_W'(coef_n);

  assign ctrl.clear = is_first && (second_q || in_i.last);
  assign ctrl.step  = step;
  assign ctrl.shift = flush_q && space;
  assign ctrl.start = start;

  assign f_link[MAX_TERMS]   = '0;
  assign acc_link[MAX_TERMS] = '0;

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
    assign sel[k] = is_first && !len_full && (len_eff == LEN_W'(k));

    pm_cell #(
      .COEF_BITS(COEF_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .sel_i  (sel[k]),
      .coef_i (coef_x),
      .f_i    (f_link[k+1]),
      .acc_i  (acc_link[k+1]),
      .f_o    (f_link[k]),
      .acc_o  (acc_link[k])
    );
  end

  assign head = acc_link[0] + pm_mul(f_link[0], coef_x);

  always_comb begin
    push = step || ctrl.shift;
    priority if (flush_q) begin
      push_data.value    = acc_link[0];
      push_data.degree   = flush_deg_q;
      push_data.last     = (flush_left_q == LEN_W'(1));
      push_data.overflow = ovf_q;
    end else begin
      push_data.value    = head;
      push_data.degree   = DEG_W'(idx_q);
      push_data.last     = in_i.last && (len_q == LEN_W'(1));
      push_data.overflow = ovf_q;
    end
  end

  always_comb begin
    len_d        = len_q;
    second_d     = second_q;
    idx_d        = idx_q;
    ovf_d        = ovf_q;
    flush_d      = flush_q;
    flush_left_d = flush_left_q;
    flush_deg_d  = flush_deg_q;

    if (is_first) begin
      len_d    = len_full ? len_eff : LEN_W'(len_eff + 1'b1);
      second_d = in_i.last;
      ovf_d    = ovf_q | len_full;
      if (ctrl.clear) begin
        idx_d = '0;
      end
    end

    if (is_second) begin
      idx_d = idx_next;
      ovf_d = ovf_q | !step;
      if (fin) begin
        len_d    = '0;
        second_d = 1'b0;
        idx_d    = '0;
      end
    end

    if (flush_go) begin
      flush_d      = 1'b1;
      flush_left_d = LEN_W'(len_q - 1'b1);
      flush_deg_d  = DEG_W'(idx_next);
    end else if (ctrl.shift) begin
      // advance to the next pending degree, drop out after the top one
      flush_left_d = LEN_W'(flush_left_q - 1'b1);
      flush_deg_d  = DEG_W'(flush_deg_q + 1'b1);
      if (flush_left_q == LEN_W'(1)) begin
        flush_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= '0;
      second_q     <= 1'b0;
      idx_q        <= '0;
      ovf_q        <= 1'b0;
      flush_q      <= 1'b0;
      flush_left_q <= '0;
      flush_deg_q  <= '0;
    end else begin
      len_q        <= len_d;
      second_q     <= second_d;
      idx_q        <= idx_d;
      ovf_q        <= ovf_d;
      flush_q      <= flush_d;
      flush_left_q <= flush_left_d;
      flush_deg_q  <= flush_deg_d;
    end
  end

  pm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .space_o     (space),
    .valid_o     (out_o.valid),
    .data_o      (buf_data),
    .ready_i     (out_o.ready)
  );

  assign out_o.product_coefficient = buf_data.value;
  assign out_o.term_degree         = buf_data.degree;
  assign out_o.last_term           = buf_data.last;
  assign out_o.overflow            = buf_data.overflow;

  `PM_ASSERT(a_no_take_in_flush, flush_q, !in_ready, "word accepted during flush")
  `PM_ASSERT(a_push_has_room, push, space, "result pushed into full output buffer")
  `PM_ASSERT(a_tail_sum_zero, 1'b1, acc_link[MAX_TERMS-1] == '0,
             "top cell holds a nonzero partial sum")
  `PM_ASSERT_NEXT(a_flush_follows, flush_go, flush_q && !second_q,
                  "flush did not start after last second word")

endmodule

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pm_pkg::*;

  localparam int TERMS        = MAX_TERMS_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_TICKS = 2 * TERMS + 16;

  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;

  logic clk;
  logic rst_n;

  pm_in_if  in_if ();
  pm_out_if out_if ();

  polynomial_multiply u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow of the multiplier
  logic signed [COEF_W-1:0] held_first [TERMS];
  int                       held_len;
  logic [SUM_W-1:0]         run_sums [TERMS-1];
  int                       next_degree;
  bit                       in_second;
  bit                       ovf_sticky;

  pm_res_t     pending_terms [$];
  int          mismatches    = 0;
  int          accepted_words = 0;
  int          burst_left    = 0;
  int          gap_max       = 0;
  int          stall_mode    = STALL_NONE;
  longint      cycles        = 0;
  logic [15:0] ready_bits;
  int          ready_age;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("polynomial_multiply: mismatch");
      $finish;
    end
  end

  // receiver stalls unless stall_mode is STALL_NONE: rotate a random pattern, renewed by ready_age
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      ready_bits   <= 16'hffff;
      ready_age    <= 0;
    end else begin
      ready_age <= ready_age + 1;
      if (stall_mode == STALL_NONE) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ready_bits[0];
        if (ready_age % 64 == 0) begin
          if (stall_mode == STALL_LIGHT) begin
            ready_bits <= 16'($urandom) | 16'h1111;
          end else begin
            ready_bits <= 16'($urandom & $urandom) | 16'h8000;
          end
        end else begin
          ready_bits <= {ready_bits[0], ready_bits[15:1]};
        end
      end
    end
  end

  function automatic logic [SUM_W-1:0] coef_product(input logic signed [COEF_W-1:0] a,
                                                    input logic signed [COEF_W-1:0] b);
    logic signed [SUM_W-1:0] wa;
    logic signed [SUM_W-1:0] wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  function automatic void drop_product();
    foreach (run_sums[i]) run_sums[i] = '0;
    next_degree = 0;
  endfunction

  function automatic void add_term(input logic [SUM_W-1:0] v, input int deg, input bit top);
    pm_res_t r;
    r.value    = v;
    r.degree   = DEG_W'(deg);
    r.last     = top;
    r.overflow = ovf_sticky;
    pending_terms.push_back(r);
  endfunction

  function automatic void predict_word(input logic op, input logic signed [COEF_W-1:0] c,
                                       input logic top);
    int n;
    logic [SUM_W-1:0] head;
    logic [SUM_W-1:0] nxt;
    if (op == OP_FIRST) begin
      accepted_words++;
      // a first word after completion abandons the pending product
      if (in_second) begin
        in_second = 1'b0;
        held_len  = 0;
        drop_product();
      end
      if (held_len < TERMS) begin
        held_first[held_len] = c;
        held_len++;
      end else begin
        ovf_sticky = 1'b1;
      end
      if (top) begin
        in_second = 1'b1;
        drop_product();
      end
      return;
    end
    if (!in_second) return;
    accepted_words++;
    n = (held_len < 1) ? 1 : held_len;
    if (next_degree < TERMS) begin
      head = coef_product(held_first[0], c) + run_sums[0];
      for (int k = 0; k + 1 < n; k++) begin
        nxt = (k + 2 < n) ? run_sums[k+1] : '0;
        run_sums[k] = nxt + coef_product(held_first[k+1], c);
      end
      add_term(head, next_degree, top && n == 1);
      next_degree++;
    end else begin
      ovf_sticky = 1'b1;
    end
    if (top) begin
      // flush the higher-degree terms
      for (int k = 0; k + 1 < n; k++) add_term(run_sums[k], next_degree + k, k + 2 == n);
      in_second = 1'b0;
      held_len  = 0;
      drop_product();
    end
  endfunction

  function automatic void report_bad(input string what, input pm_res_t exp_r,
                                     input pm_res_t got_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR cycle %0d: %s: exp value=%0d deg=%0d last=%0b ovf=%0b",
               cycles, what, $signed(exp_r.value), exp_r.degree, exp_r.last,
               exp_r.overflow);
      $display("  got value=%0d deg=%0d last=%0b ovf=%0b",
               $signed(got_r.value), got_r.degree, got_r.last, got_r.overflow);
    end
  endfunction

  always @(posedge clk) begin : check_terms
    pm_res_t got_r;
    pm_res_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      got_r.value    = out_if.product_coefficient;
      got_r.degree   = out_if.term_degree;
      got_r.last     = out_if.last_term;
      got_r.overflow = out_if.overflow;
      if (pending_terms.size() == 0) begin
        exp_r = '0;
        report_bad("unexpected term", exp_r, got_r);
      end else begin
        exp_r = pending_terms.pop_front();
        if (got_r.value !== exp_r.value || got_r.degree !== exp_r.degree ||
            got_r.last !== exp_r.last || got_r.overflow !== exp_r.overflow) begin
          report_bad("wrong term", exp_r, got_r);
        end
      end
    end
  end

  task automatic send_word(input logic op, input logic signed [COEF_W-1:0] c, input logic top);
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.coefficient <= c;
    in_if.last        <= top;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_word(op, c, top);
  endtask

  // hold off until every predicted term has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_terms.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return COEF_W'($urandom_range(0, 31)) - COEF_W'(16);
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic int rand_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(1, TERMS);
    return $urandom_range(1, 6);
  endfunction

  task automatic send_poly(input logic op, input int len);
    for (int i = 0; i < len; i++) send_word(op, rand_coef(), i == len - 1);
  endtask

  task automatic test_directed();
    gap_max    = 0;
    stall_mode = STALL_NONE;
    // second words with no first polynomial loaded
    send_word(OP_SECOND, 16'sh1234, 1'b0);
    send_word(OP_SECOND, 16'sh8000, 1'b1);
    // extremes, with a full pause between the two polynomials
    send_word(OP_FIRST, 16'sh7fff, 1'b0);
    send_word(OP_FIRST, 16'sh8000, 1'b1);
    wait_drained();
    send_word(OP_SECOND, 16'sh8000, 1'b0);
    send_word(OP_SECOND, 16'sh7fff, 1'b1);
    // one-term first polynomials, against a one-term and a three-term second
    send_word(OP_FIRST, 16'sh8000, 1'b1);
    send_word(OP_SECOND, 16'sh8000, 1'b1);
    send_word(OP_FIRST, 16'sh0001, 1'b1);
    send_word(OP_SECOND, 16'shffff, 1'b0);
    send_word(OP_SECOND, 16'sh7fff, 1'b0);
    send_word(OP_SECOND, 16'sh8000, 1'b1);
    // first word during the second polynomial abandons the product
    send_word(OP_FIRST, 16'sh0003, 1'b0);
    send_word(OP_FIRST, -16'sh0005, 1'b0);
    send_word(OP_FIRST, 16'sh0007, 1'b1);
    send_word(OP_SECOND, 16'sh0100, 1'b0);
    send_word(OP_SECOND, 16'sh0200, 1'b0);
    send_word(OP_FIRST, 16'sh0011, 1'b1);
    send_word(OP_SECOND, -16'sh0001, 1'b1);
    // largest sums
    repeat (4) send_word(OP_FIRST, 16'sh8000, 1'b0);
    send_word(OP_FIRST, 16'sh8000, 1'b1);
    send_word(OP_SECOND, 16'sh8000, 1'b0);
    send_word(OP_SECOND, 16'sh8000, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(input int word_goal, input int gaps, input int mode);
    int goal;
    int pick;
    gap_max    = gaps;
    stall_mode = mode;
    burst_left = 0;
    goal       = accepted_words + word_goal;
    while (accepted_words < goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
        send_poly(OP_FIRST, rand_len());
        send_poly(OP_SECOND, rand_len());
      end else if (pick == 16) begin
        send_word(OP_SECOND, rand_coef(), 1'($urandom_range(0, 1)));
      end else if (pick == 17) begin
        // second polynomial left open, the next first word drops it
        send_poly(OP_FIRST, rand_len());
        repeat (rand_len()) send_word(OP_SECOND, rand_coef(), 1'b0);
      end else if (pick == 18) begin
        repeat ($urandom_range(1, 6))
          send_word(1'($urandom_range(0, 1)), rand_coef(), 1'($urandom_range(0, 1)));
      end else begin
        send_poly(OP_FIRST, rand_len());
        wait_drained();
        send_poly(OP_SECOND, rand_len());
      end
    end
    wait_drained();
  endtask

  task automatic test_first_overflow();
    gap_max    = 4;
    stall_mode = STALL_LIGHT;
    send_poly(OP_FIRST, TERMS + 2);
    send_poly(OP_SECOND, 3);
    wait_drained();
  endtask

  task automatic test_second_overflow();
    gap_max    = 3;
    stall_mode = STALL_LIGHT;
    send_poly(OP_FIRST, 3);
    send_poly(OP_SECOND, TERMS + 3);
    // one-term first: the ignored last word flushes nothing
    send_poly(OP_FIRST, 1);
    send_poly(OP_SECOND, TERMS + 2);
    wait_drained();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.operation   <= OP_FIRST;
    in_if.coefficient <= '0;
    in_if.last        <= 1'b0;
    foreach (held_first[i]) held_first[i] = '0;
    held_len   = 0;
    in_second  = 1'b0;
    ovf_sticky = 1'b0;
    drop_product();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    test_directed();
    test_random(90, 0, STALL_NONE);
    test_random(100, 6, STALL_LIGHT);
    test_random(90, 10, STALL_HEAVY);
    // overflow is sticky, so these run after the tests that expect it clear
    test_first_overflow();
    test_second_overflow();
    test_random(25, 4, STALL_LIGHT);

    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatches == 0 && pending_terms.size() == 0) begin
      $display("polynomial_multiply: match");
    end else begin
      $display("polynomial_multiply: mismatch");
    end
    $finish;
  end

endmodule
